// ----- hdl/sbphm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbphm_pkg
// Shared widths, reset values and types of the spectrum band peak hold meter.
// ----------------------------------------------------------------------------
package sbphm_pkg;

  // Default sizes of the meter.
  localparam int BANDS_DEF       = 32;
  localparam int BIN_WIDTH_DEF   = 24;
  localparam int LEVEL_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int BAND_W  = 5;
  localparam int FLOOR_W = 8;
  localparam int HEAD_W  = 5;
  localparam int DECAY_W = 16;
  localparam int HOLD_W  = 8;
  localparam int AGE_W   = 8;

  // Signed dB value in 1/16 dB steps, and the clamped span below full level.
  localparam int DB_W   = 16;
  localparam int SPAN_W = 12;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [FLOOR_W-1:0] FLOOR_RST       = 8'hBA;  // -70 dB
  localparam logic [HEAD_W-1:0]  HEAD_RST        = 5'd0;
  localparam logic [DECAY_W-1:0] LEVEL_DECAY_RST = 16'd51118;
  localparam logic [DECAY_W-1:0] PEAK_DECAY_RST  = 16'd60293;
  localparam logic [HOLD_W-1:0]  HOLD_RST        = 8'd18;

  // A finished band maximum handed from the power front end to the sequencer.
  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] band;
  } job_t;

endpackage

// ----- hdl/sbphm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbphm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port that holds its data until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sbphm_pow.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbphm_pow
// Bin power front end: squares each bin and tracks the band's running maximum.
// ----------------------------------------------------------------------------
module sbphm_pow
  import sbphm_pkg::*;
#(
  parameter int BIN_WIDTH = BIN_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [BAND_W-1:0]           band,
  input  logic signed [BIN_WIDTH-1:0] bin_real,
  input  logic signed [BIN_WIDTH-1:0] bin_imag,
  input  logic                        band_end,
  output job_t                        job,
  output logic [2*BIN_WIDTH-1:0]      mx
);

  localparam int PW = 2 * BIN_WIDTH;

  logic                 v1;
  logic                 v2;
  logic [BIN_WIDTH-1:0] mag_re;
  logic [BIN_WIDTH-1:0] mag_im;
  logic [BAND_W-1:0]    band1;
  logic [BAND_W-1:0]    band2;
  logic                 end1;
  logic                 end2;
  logic [PW-1:0]        sq_re;
  logic [PW-1:0]        sq_im;
  logic [PW-1:0]        run_max;
  logic [PW-1:0]        power;
  logic [PW-1:0]        max_next;

  // The sum of two squares cannot carry out of PW bits.
  always_comb begin
    power    = sq_re + sq_im;
    max_next = (power > run_max) ? power : run_max;
  end

  // Control: valid flags, running maximum and the job pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      run_max   <= '0;
      job.valid <= 1'b0;
    end else begin
      v1        <= accept;
      v2        <= v1;
      job.valid <= v2 && end2;
      if (v2) begin
        run_max <= end2 ? '0 : max_next;
      end
    end
  end

  // Payload: magnitudes, squares and the band maximum at the end of a band.
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_re <= bin_real[BIN_WIDTH-1] ? BIN_WIDTH'(-bin_real) : BIN_WIDTH'(bin_real);
      mag_im <= bin_imag[BIN_WIDTH-1] ? BIN_WIDTH'(-bin_imag) : BIN_WIDTH'(bin_imag);
      band1  <= band;
      end1   <= band_end;
    end
    if (v1) begin
      sq_re <= PW'(mag_re) * PW'(mag_re);
      sq_im <= PW'(mag_im) * PW'(mag_im);
      band2 <= band1;
      end2  <= end1;
    end
    if (v2 && end2) begin
      mx       <= max_next;
      job.band <= band2;
    end
  end

endmodule

// ----- hdl/sbphm_log.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbphm_log
// Multi-cycle power to dB converter: normalize, log2 polynomial, dB scaling.
// ----------------------------------------------------------------------------
module sbphm_log
  import sbphm_pkg::*;
#(
  parameter int BIN_WIDTH = BIN_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*BIN_WIDTH-1:0] power,
  output logic                   done,
  output logic signed [DB_W-1:0] db16
);

  localparam int PW         = 2 * BIN_WIDTH;
  localparam int K          = $clog2(PW);
  localparam int NW         = 1 << K;
  localparam int SW         = $clog2(K);
  localparam int LOG_OFFSET = 2 * (BIN_WIDTH - 1);
  localparam int CORR_MUL   = 22;
  localparam int L2W        = 26;
  localparam int PRW        = L2W + 24;
  localparam logic signed [23:0] DB_SCALE = 24'sd3156528;  // 16*10*log10(2), Q16

  typedef enum logic [2:0] {
    L_IDLE,
    L_NORM,
    L_POLY,
    L_CORR,
    L_DB,
    L_RND
  } log_state_t;

  log_state_t            state;
  logic [NW-1:0]         norm;
  logic [K-1:0]          lz;
  logic [SW-1:0]         step;
  logic [K-1:0]          sh;
  logic [NW-1:0]         top_mask;
  logic [NW+15:0]        ext;
  logic [15:0]           x_n;
  logic [15:0]           x_q;
  logic [32:0]           prod_full;
  logic [30:0]           prod;
  logic [35:0]           corr_full;
  logic [13:0]           corr;
  logic signed [7:0]     de;
  logic signed [L2W-1:0] l2;
  logic signed [PRW-1:0] dbp;
  logic [PRW-1:0]        rnd;

  // Datapath terms of the current step.
  always_comb begin
    sh        = K'(1) << step;
    top_mask  = ~({NW{1'b1}} >> sh);
    ext       = {norm, 16'h0000};
    x_n       = ext[NW+14 -: 16];
    prod_full = 33'(x_n) * (33'(17'h10000) - 33'(x_n));
    corr_full = 36'(prod) * 36'(CORR_MUL);
    corr      = corr_full[35:22];
    rnd       = dbp + (PRW'(1) << 31);
  end

  // Sequencer: a binary leading-one search, then one multiply per step and a rounding step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            norm  <= NW'(power);
            lz    <= '0;
            step  <= SW'(K - 1);
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if ((norm & top_mask) == '0) begin
            norm <= norm << sh;
            lz   <= lz + sh;
          end
          if (step == '0) begin
            state <= L_POLY;
          end else begin
            step <= step - 1'b1;
          end
        end
        L_POLY: begin
          x_q   <= x_n;
          de    <= 8'(NW - 1) - 8'(lz) - 8'(LOG_OFFSET);
          prod  <= prod_full[30:0];
          state <= L_CORR;
        end
        L_CORR: begin
          l2    <= (L2W'(de) <<< 16) + L2W'(x_q) + L2W'(corr);
          state <= L_DB;
        end
        L_DB: begin
          dbp   <= PRW'(l2) * PRW'(DB_SCALE);
          state <= L_RND;
        end
        L_RND: begin
          db16  <= rnd[32+DB_W-1:32];
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/sbphm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbphm_div
// Restoring divider that gives the fraction num/den, num < den, one bit a cycle.
// ----------------------------------------------------------------------------
module sbphm_div
  import sbphm_pkg::*;
#(
  parameter int QW = LEVEL_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SPAN_W-1:0] num,
  input  logic [SPAN_W-1:0] den,
  output logic              done,
  output logic [QW-1:0]     quo
);

  localparam int CW = $clog2(QW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W:0]   r2;
  logic [SPAN_W:0]   diff;
  logic              take;

  // One trial subtraction of the doubled remainder.
  always_comb begin
    r2   = {rem, 1'b0};
    diff = r2 - {1'b0, den};
    take = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        quo  <= '0;
        cnt  <= CW'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= take ? diff[SPAN_W-1:0] : r2[SPAN_W-1:0];
        quo <= {quo[QW-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/spectrum_band_peak_hold_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_peak_hold_meter
// Inner bins are taken one per cycle. A band_end item holds the input stalled
// until its result is in the output register, a wait that is set by the dB
// converter and the one-bit-a-cycle level divider. An out-of-range band frees
// it once its job reaches the idle sequencer.
// Reset clears the registers to their defaults and all band levels, peaks and
// ages to zero at once through per-band valid bits.
// ----------------------------------------------------------------------------
module spectrum_band_peak_hold_meter
  import sbphm_pkg::*;
#(
  parameter int BANDS       = BANDS_DEF,        // 2 to 32
  parameter int BIN_WIDTH   = BIN_WIDTH_DEF,    // 8 to 32
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF   // 8 to 24
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready,
  // Bin items
  input  logic                          bin_valid,
  output logic                          bin_stall,
  input  logic [BAND_W-1:0]             band,
  input  logic signed [BIN_WIDTH-1:0]   bin_real,
  input  logic signed [BIN_WIDTH-1:0]   bin_imag,
  input  logic                          band_end,
  // Meter items
  output logic                          meter_valid,
  input  logic                          meter_stall,
  output logic [BAND_W-1:0]             out_band,
  output logic [LEVEL_WIDTH-1:0]        level,
  output logic [LEVEL_WIDTH-1:0]        peak
);

  localparam int LW = LEVEL_WIDTH;
  localparam int PW = 2 * BIN_WIDTH;
  localparam int AW = $clog2(BANDS);
  localparam int EW = 2 * LW + AGE_W;
  localparam int MW = LW + DECAY_W;

  localparam logic [2:0] REG_FLOOR    = 3'd0;
  localparam logic [2:0] REG_HEADROOM = 3'd1;
  localparam logic [2:0] REG_LDECAY   = 3'd2;
  localparam logic [2:0] REG_PDECAY   = 3'd3;
  localparam logic [2:0] REG_HOLD     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG,
    S_CLAMP,
    S_DIV,
    S_LVL,
    S_WR
  } seq_state_t;

  // Configuration registers.
  logic [FLOOR_W-1:0] floor_db;
  logic [HEAD_W-1:0]  headroom_db;
  logic [DECAY_W-1:0] level_decay;
  logic [DECAY_W-1:0] peak_decay;
  logic [HOLD_W-1:0]  hold_frames;
  logic [2:0]         cfg_idx;

  // Sequencer state.
  seq_state_t         state;
  logic               busy;
  logic               accept;
  job_t               job;
  logic [PW-1:0]      mx;
  logic               in_range;
  logic               mx_zero;
  logic [AW-1:0]      addr_q;
  logic [BAND_W-1:0]  band_q;
  logic               ent_vld;
  logic [BANDS-1:0]   vld;
  logic               div_go;
  logic               slot_free;
  logic               load;

  // Converter and divider links.
  logic               log_start;
  logic               log_done;
  logic signed [DB_W-1:0] db16;
  logic               div_done;
  logic [LW-1:0]      quo;

  // Memory links.
  logic               ram_re;
  logic [EW-1:0]      ram_rdata;
  logic [EW-1:0]      ent;
  logic [EW-1:0]      ent_next;

  // Clamp and span.
  logic signed [DB_W-1:0] f16;
  logic signed [DB_W-1:0] h16;
  logic signed [DB_W-1:0] db_sel;
  logic signed [DB_W-1:0] db_lo;
  logic signed [DB_W-1:0] db_cl;
  logic signed [DB_W-1:0] span;
  logic signed [DB_W-1:0] num;
  logic [SPAN_W-1:0]  num_q;
  logic [SPAN_W-1:0]  span_q;
  logic               span_pos;
  logic               full;

  // Level, peak and age update.
  logic [LW-1:0]      lvl_old;
  logic [LW-1:0]      pk_old;
  logic [AGE_W-1:0]   age_old;
  logic [MW-1:0]      lvl_prod;
  logic [MW-1:0]      pk_prod;
  logic [LW-1:0]      dec_lvl;
  logic [LW-1:0]      dec_pk;
  logic [LW-1:0]      frac;
  logic [LW-1:0]      lvl_q;
  logic               rising;
  logic [AGE_W-1:0]   age_inc;
  logic [AGE_W-1:0]   age_next;
  logic [LW-1:0]      dp_max;
  logic [LW-1:0]      pk_next;

  // Configuration port: writes, and reads of the current values.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_db    <= FLOOR_RST;
      headroom_db <= HEAD_RST;
      level_decay <= LEVEL_DECAY_RST;
      peak_decay  <= PEAK_DECAY_RST;
      hold_frames <= HOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_idx)
        REG_FLOOR:    floor_db    <= pwdata[FLOOR_W-1:0];
        REG_HEADROOM: headroom_db <= pwdata[HEAD_W-1:0];
        REG_LDECAY:   level_decay <= pwdata[DECAY_W-1:0];
        REG_PDECAY:   peak_decay  <= pwdata[DECAY_W-1:0];
        REG_HOLD:     hold_frames <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FLOOR:    prdata = {{(CFG_DATA_W-FLOOR_W){floor_db[FLOOR_W-1]}}, floor_db};
      REG_HEADROOM: prdata = CFG_DATA_W'(headroom_db);
      REG_LDECAY:   prdata = CFG_DATA_W'(level_decay);
      REG_PDECAY:   prdata = CFG_DATA_W'(peak_decay);
      REG_HOLD:     prdata = CFG_DATA_W'(hold_frames);
      default:      prdata = '0;
    endcase
  end

  // Bin handshake: inner bins flow freely, a band end holds the port.
  assign bin_stall = busy;
  assign accept    = bin_valid && !bin_stall;

  sbphm_pow #(
    .BIN_WIDTH (BIN_WIDTH)
  ) u_pow (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .band     (band),
    .bin_real (bin_real),
    .bin_imag (bin_imag),
    .band_end (band_end),
    .job      (job),
    .mx       (mx)
  );

  assign in_range  = (int'(job.band) < BANDS);
  assign log_start = (state == S_IDLE) && job.valid && in_range;
  assign ram_re    = log_start;

  sbphm_log #(
    .BIN_WIDTH (BIN_WIDTH)
  ) u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .power (mx),
    .done  (log_done),
    .db16  (db16)
  );

  sbphm_div #(
    .QW (LW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (num_q),
    .den   (span_q),
    .done  (div_done),
    .quo   (quo)
  );

  // Band store: level, peak and age of each band in one entry.
  sbphm_ram #(
    .WIDTH (EW),
    .DEPTH (BANDS)
  ) u_ram (
    .clk   (clk),
    .we    (load),
    .waddr (addr_q),
    .wdata (ent_next),
    .re    (ram_re),
    .raddr (AW'(job.band)),
    .rdata (ram_rdata)
  );

  // An entry never written since reset reads as zero.
  always_comb begin
    ent     = ent_vld ? ram_rdata : '0;
    lvl_old = ent[LW-1:0];
    pk_old  = ent[2*LW-1:LW];
    age_old = ent[EW-1:2*LW];
  end

  // dB clamp to [floor, headroom] and the span that maps onto full level.
  always_comb begin
    f16    = {{(DB_W-FLOOR_W-4){floor_db[FLOOR_W-1]}}, floor_db, 4'b0000};
    h16    = {{(DB_W-HEAD_W-4){1'b0}}, headroom_db, 4'b0000};
    db_sel = mx_zero ? f16 : db16;
    db_lo  = (db_sel < f16) ? f16 : db_sel;
    db_cl  = (db_lo > h16) ? h16 : db_lo;
    span   = h16 - f16;
    num    = db_cl - f16;
  end

  // Per-frame decay of the stored level and peak.
  always_comb begin
    lvl_prod = MW'(lvl_old) * MW'(level_decay);
    pk_prod  = MW'(pk_old) * MW'(peak_decay);
    dec_lvl  = lvl_prod[MW-1:DECAY_W];
    dec_pk   = pk_prod[MW-1:DECAY_W];
  end

  // New fraction, with an empty span giving zero and full scale saturating.
  always_comb begin
    if (!span_pos) begin
      frac = '0;
    end else if (full) begin
      frac = '1;
    end else begin
      frac = quo;
    end
  end

  // Peak follows the level up, holds, then decays toward the level.
  always_comb begin
    rising   = (lvl_q >= pk_old);
    age_inc  = (age_old == '1) ? age_old : age_old + 1'b1;
    dp_max   = (dec_pk > lvl_q) ? dec_pk : lvl_q;
    if (rising) begin
      pk_next  = lvl_q;
      age_next = '0;
    end else begin
      pk_next  = (age_inc > hold_frames) ? dp_max : pk_old;
      age_next = age_inc;
    end
    ent_next = {age_next, pk_next, lvl_q};
  end

  assign slot_free = !meter_valid || !meter_stall;
  assign load      = (state == S_WR) && slot_free;

  // Valid bits of the band store.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (load) begin
      vld[addr_q] <= 1'b1;
    end
  end

  // Band update sequencer and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy        <= 1'b0;
      div_go      <= 1'b0;
      meter_valid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (accept && band_end) begin
        busy <= 1'b1;
      end
      if (load) begin
        meter_valid <= 1'b1;
      end else if (!meter_stall) begin
        meter_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job.valid) begin
            if (in_range) begin
              mx_zero <= (mx == '0);
              addr_q  <= AW'(job.band);
              band_q  <= job.band;
              ent_vld <= vld[AW'(job.band)];
              state   <= S_LOG;
            end else begin
              busy <= 1'b0;
            end
          end
        end
        S_LOG: begin
          if (log_done || mx_zero) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          num_q    <= num[SPAN_W-1:0];
          span_q   <= span[SPAN_W-1:0];
          span_pos <= (span > 0);
          full     <= (num >= span);
          div_go   <= 1'b1;
          state    <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_LVL;
          end
        end
        S_LVL: begin
          lvl_q <= (dec_lvl > frac) ? dec_lvl : frac;
          state <= S_WR;
        end
        S_WR: begin
          if (slot_free) begin
            out_band <= band_q;
            level    <= lvl_q;
            peak     <= pk_next;
            busy     <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/spectrum_band_peak_hold_meter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_peak_hold_meter_tb
// Drives FFT bin items into the band meter and checks every meter item against
// a band-by-band prediction of level, peak and hold age. The run goes through
// several register settings and mixes input gaps, output stalls, a long
// output hold-off and a drain pause with directed and random band sequences.
// ----------------------------------------------------------------------------
module spectrum_band_peak_hold_meter_tb;
  import sbphm_pkg::*;

  // Register indexes of the configuration port.
  localparam int REG_FLOOR_DB    = 0;
  localparam int REG_HEADROOM_DB = 1;
  localparam int REG_LEVEL_DECAY = 2;
  localparam int REG_PEAK_DECAY  = 3;
  localparam int REG_HOLD_FRAMES = 4;

  localparam int  BW               = BIN_WIDTH_DEF;
  localparam int  LW               = LEVEL_WIDTH_DEF;
  localparam longint DB16_PER_LOG2 = 3156528;  // 16 * 10*log10(2) in Q16
  localparam int  SETTLE_CYCLES    = 60;       // above the band update time
  localparam int  LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [LW-1:0]     level;
    logic [LW-1:0]     peak;
  } meter_t;

  // Tracks the meter state per band and the meter items still due.
  class band_meter_tracker;
    logic signed [FLOOR_W-1:0] floor_db;
    logic [HEAD_W-1:0]         headroom_db;
    logic [DECAY_W-1:0]        level_decay;
    logic [DECAY_W-1:0]        peak_decay;
    logic [HOLD_W-1:0]         hold_frames;
    longint unsigned           band_max;
    logic [LW-1:0]             level_mem[BANDS_DEF];
    logic [LW-1:0]             peak_mem[BANDS_DEF];
    logic [AGE_W-1:0]          age_mem[BANDS_DEF];
    meter_t                    due_meters[$];
    int                        errors;
    int                        checked;

    function new();
      floor_db    = FLOOR_RST;
      headroom_db = HEAD_RST;
      level_decay = LEVEL_DECAY_RST;
      peak_decay  = PEAK_DECAY_RST;
      hold_frames = HOLD_RST;
      band_max    = 0;
      errors      = 0;
      checked     = 0;
      for (int i = 0; i < BANDS_DEF; i++) begin
        level_mem[i] = '0;
        peak_mem[i]  = '0;
        age_mem[i]   = '0;
      end
    endfunction

    function void set_reg(int idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FLOOR_DB:    floor_db    = val[FLOOR_W-1:0];
        REG_HEADROOM_DB: headroom_db = val[HEAD_W-1:0];
        REG_LEVEL_DECAY: level_decay = val[DECAY_W-1:0];
        REG_PEAK_DECAY:  peak_decay  = val[DECAY_W-1:0];
        REG_HOLD_FRAMES: hold_frames = val[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    // Power relative to full scale in 1/16 dB steps, from a Q16 log2 estimate.
    function longint power_to_db16(longint unsigned pw);
      int              e;
      longint unsigned x;
      longint unsigned corr;
      longint          lg;
      e = 63;
      while (e > 0 && pw[e] == 1'b0) e--;
      if (e >= 16) x = (pw >> (e - 16)) & 64'hFFFF;
      else x = (pw << (16 - e)) & 64'hFFFF;
      corr = (x * (64'd65536 - x) * 64'd22) >> 22;
      lg = (longint'(e) << 16) + longint'(x) + longint'(corr)
           - (longint'(2 * (BW - 1)) << 16);
      return (lg * DB16_PER_LOG2 + (longint'(1) << 31)) >>> 32;
    endfunction

    function logic [LW-1:0] scaled_by(logic [LW-1:0] v, logic [DECAY_W-1:0] f);
      logic [31:0] prod;
      prod = {16'b0, v} * {16'b0, f};
      return prod[31:16];
    endfunction

    // Folds one accepted bin into the band maximum; a band end updates the meter.
    function void take_bin(logic [BAND_W-1:0] b, logic signed [BW-1:0] re,
                           logic signed [BW-1:0] im, logic last);
      longint          r;
      longint          q;
      longint unsigned pw;
      longint unsigned mx;
      longint          f16;
      longint          h16;
      longint          db;
      longint          span;
      longint unsigned frac;
      logic [LW-1:0]   dec;
      logic [LW-1:0]   lvl;
      logic [LW-1:0]   pk;
      logic [LW-1:0]   dp;
      meter_t          m;
      r = re;
      q = im;
      if (r < 0) r = -r;
      if (q < 0) q = -q;
      pw = longint'(r * r + q * q);
      if (pw > band_max) band_max = pw;
      if (!last) return;
      mx = band_max;
      band_max = 0;

      // Clamp the dB value into [floor, headroom] and map it onto the level scale.
      f16 = longint'(floor_db) * 16;
      h16 = longint'({1'b0, headroom_db}) * 16;
      db = (mx == 0) ? f16 : power_to_db16(mx);
      if (db < f16) db = f16;
      if (db > h16) db = h16;
      span = h16 - f16;
      if (span <= 0) begin
        frac = 0;
      end else begin
        frac = longint'(((db - f16) << LW) / span);
        if (frac > (64'd1 << LW) - 1) frac = (64'd1 << LW) - 1;
      end

      // Level follows the larger of the new value and its decayed past.
      dec = scaled_by(level_mem[b], level_decay);
      lvl = (dec > frac) ? dec : frac[LW-1:0];
      level_mem[b] = lvl;

      // Peak rises with the level, holds, then decays once the hold runs out.
      pk = peak_mem[b];
      if (lvl >= pk) begin
        pk = lvl;
        age_mem[b] = '0;
      end else begin
        if (age_mem[b] != '1) age_mem[b] = age_mem[b] + 1'b1;
        if (age_mem[b] > hold_frames) begin
          dp = scaled_by(pk, peak_decay);
          pk = (dp > lvl) ? dp : lvl;
        end
      end
      peak_mem[b] = pk;

      m.band  = b;
      m.level = lvl;
      m.peak  = pk;
      due_meters.push_back(m);
    endfunction

    function void match_meter(logic [BAND_W-1:0] b, logic [LW-1:0] lvl,
                              logic [LW-1:0] pk);
      meter_t m;
      if (due_meters.size() == 0) begin
        errors++;
        $display("%0t: unexpected meter item: band %0d level %0d peak %0d",
                 $time, b, lvl, pk);
        return;
      end
      m = due_meters.pop_front();
      checked++;
      if (b !== m.band) begin
        errors++;
        $display("%0t: out_band mismatch: expected %0d actual %0d", $time, m.band, b);
      end
      if (lvl !== m.level) begin
        errors++;
        $display("%0t: level mismatch on band %0d: expected %0d actual %0d",
                 $time, m.band, m.level, lvl);
      end
      if (pk !== m.peak) begin
        errors++;
        $display("%0t: peak mismatch on band %0d: expected %0d actual %0d",
                 $time, m.band, m.peak, pk);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   bin_valid = 1'b0;
  logic                   bin_stall;
  logic [BAND_W-1:0]      band = '0;
  logic signed [BW-1:0]   bin_real = '0;
  logic signed [BW-1:0]   bin_imag = '0;
  logic                   band_end = 1'b0;
  logic                   meter_valid;
  logic                   meter_stall = 1'b0;
  logic [BAND_W-1:0]      out_band;
  logic [LW-1:0]          level;
  logic [LW-1:0]          peak;

  band_meter_tracker tracker = new();
  int  tx_pct = 0;
  int  rx_pct = 0;
  int  bins_in = 0;
  int  settings = 0;
  bit  hold_req = 1'b0;
  logic long_hold = 1'b0;

  spectrum_band_peak_hold_meter dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bin_valid   (bin_valid),
    .bin_stall   (bin_stall),
    .band        (band),
    .bin_real    (bin_real),
    .bin_imag    (bin_imag),
    .band_end    (band_end),
    .meter_valid (meter_valid),
    .meter_stall (meter_stall),
    .out_band    (out_band),
    .level       (level),
    .peak        (peak)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: random stalls, forced high during the long hold-off.
  always @(posedge clk) begin
    meter_stall <= long_hold || ($urandom_range(0, 99) < rx_pct);
  end

  // Long output hold-off while the sender keeps offering items.
  initial begin
    wait (hold_req);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Accepted bin items feed the prediction.
  always @(posedge clk) begin
    if (!rst && bin_valid && !bin_stall) begin
      bins_in++;
      tracker.take_bin(band, bin_real, bin_imag, band_end);
    end
  end

  // Accepted meter items are checked in order.
  always @(posedge clk) begin
    if (!rst && meter_valid && !meter_stall) begin
      tracker.match_meter(out_band, level, peak);
    end
  end

  task automatic send_bin(input logic [BAND_W-1:0] b, input logic signed [BW-1:0] re,
                          input logic signed [BW-1:0] im, input logic last);
    if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      bin_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_pct);
    end
    bin_valid <= 1'b1;
    band      <= b;
    bin_real  <= re;
    bin_imag  <= im;
    band_end  <= last;
    do @(posedge clk); while (bin_stall);
  endtask

  // Setup cycle, then access cycle until pready.
  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, val);
  endtask

  // Sender idles until every due meter item is out, then lets the block settle.
  task automatic wait_meters_out();
    bin_valid <= 1'b0;
    do @(posedge clk); while (tracker.due_meters.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic signed [FLOOR_W-1:0] fl,
                               input logic [HEAD_W-1:0] hd,
                               input logic [DECAY_W-1:0] ld,
                               input logic [DECAY_W-1:0] pd,
                               input logic [HOLD_W-1:0] hf, input int tx, input int rx);
    wait_meters_out();
    write_reg(REG_FLOOR_DB, {24'b0, fl});
    write_reg(REG_HEADROOM_DB, {27'b0, hd});
    write_reg(REG_LEVEL_DECAY, {16'b0, ld});
    write_reg(REG_PEAK_DECAY, {16'b0, pd});
    write_reg(REG_HOLD_FRAMES, {24'b0, hf});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tx_pct  = tx;
    rx_pct  = rx;
    settings++;
  endtask

  // Bin component: loud near full scale, or of random size and sign.
  function automatic logic signed [BW-1:0] bin_value(bit loud);
    logic signed [BW-1:0] v;
    int                   sh;
    if (loud) begin
      v = BW'($urandom_range(6000000, 8388607));
    end else if ($urandom_range(0, 9) == 0) begin
      v = BW'($urandom);
    end else begin
      sh = $urandom_range(0, BW - 1);
      v = BW'($urandom & ((32'd1 << sh) - 1));
    end
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Mostly well-formed bands on a few busy bands, plus loose noise bins.
  task automatic run_frames(input int n_items);
    int               sent;
    int               nb;
    bit               loud;
    logic [BAND_W-1:0] b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        b = ($urandom_range(0, 3) != 0) ? BAND_W'($urandom_range(0, 3))
                                        : BAND_W'($urandom);
        nb = $urandom_range(1, 5);
        loud = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < nb; i++) begin
          send_bin((i == nb - 1) ? b : BAND_W'($urandom), bin_value(loud),
                   bin_value(loud), i == nb - 1);
        end
        sent += nb;
      end else begin
        send_bin(BAND_W'($urandom), BW'($urandom), BW'($urandom),
                 $urandom_range(0, 3) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bands at reset settings: silence, full scale, inner bins.
    send_bin(5'd0, '0, '0, 1'b1);
    send_bin(5'd31, 24'sh800000, 24'sh800000, 1'b1);
    send_bin(5'd1, 24'sh7FFFFF, '0, 1'b1);
    send_bin(5'd2, '0, 24'sh800000, 1'b1);
    send_bin(5'd3, 24'sd1, '0, 1'b1);
    send_bin(5'd9, 24'sd100, -24'sd3, 1'b0);
    send_bin(5'd17, 24'sd5000000, 24'sd2000, 1'b0);
    send_bin(5'd22, -24'sd3, 24'sd7, 1'b0);
    send_bin(5'd4, 24'sd12, 24'sd1, 1'b1);
    send_bin(5'd4, '0, '0, 1'b1);
    send_bin(5'd0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    for (int i = 0; i < 6; i++) send_bin(5'd31, '0, '0, 1'b1);
    send_bin(5'd5, 24'sh100000, '0, 1'b1);
    send_bin(5'd5, 24'sh001000, -24'sh001000, 1'b1);
    send_bin(5'd6, 24'sh155555, 24'shEAAAAB, 1'b1);

    // Extreme settings: a wide span of -120 to 20 dB, no decay, no hold; then the
    // narrowest non-empty span, full decay, longest hold short of saturation.
    apply_setting(-120, 20, 16'hFFFF, 16'hFFFF, 8'd0, 70, 0);
    run_frames(150);
    apply_setting(-1, 0, 16'd0, 16'd0, 8'd254, 0, 70);
    run_frames(150);

    // Floor set above headroom: empty span, every level fraction is zero.
    apply_setting(8, 2, 16'd40000, 16'd30000, 8'd0, 13, 13);
    run_frames(120);

    // Hold of 255: one loud update, then enough quiet ones to saturate the age.
    apply_setting(-90, 10, 16'd51118, 16'd60293, 8'd255, 0, 0);
    send_bin(5'd7, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    for (int i = 0; i < 280; i++) begin
      send_bin(5'd7, BW'($urandom_range(0, 4095)), BW'($urandom_range(0, 4095)), 1'b1);
    end

    // Random settings, cycling through the idle modes.
    for (int k = 0; k < 6; k++) begin
      case (k % 4)
        0: apply_setting(-$urandom_range(1, 120), $urandom_range(0, 20),
                         $urandom, $urandom, $urandom_range(0, 30), 0, 0);
        1: apply_setting(-$urandom_range(1, 120), $urandom_range(0, 20),
                         $urandom, $urandom, $urandom_range(0, 30), 70, 0);
        2: apply_setting(-$urandom_range(1, 120), $urandom_range(0, 20),
                         $urandom, $urandom, $urandom_range(0, 254), 0, 70);
        default: apply_setting(-$urandom_range(1, 120), $urandom_range(0, 20),
                               $urandom, $urandom, $urandom_range(0, 30), 13, 13);
      endcase
      if (k == 0) hold_req = 1'b1;
      if (k == 1) begin
        run_frames(90);
        wait_meters_out();
        run_frames(90);
      end else begin
        run_frames(180);
      end
    end

    wait_meters_out();
    if (tracker.due_meters.size() != 0) begin
      tracker.errors++;
      $display("%0t: %0d meter items never arrived", $time, tracker.due_meters.size());
    end
    $display("Covered %0d bins and %0d band updates over %0d register settings,",
             bins_in, tracker.checked, settings);
    $display("with input gaps, output stalls, a %0d-cycle output hold-off and a drain.",
             LONG_HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("spectrum_band_peak_hold_meter_tb: PASS");
    end else begin
      $display("spectrum_band_peak_hold_meter_tb: FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("%0t: run limit reached", $time);
    $display("spectrum_band_peak_hold_meter_tb: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sbphm_pkg.sv
hdl/sbphm_ram.sv
hdl/sbphm_pow.sv
hdl/sbphm_log.sv
hdl/sbphm_div.sv
hdl/spectrum_band_peak_hold_meter.sv
tb/spectrum_band_peak_hold_meter_tb.sv
